FILE: design/echo_command_link_sequencer_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the echo command link sequencer
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ECHO_COMMAND_LINK_SEQUENCER_UNIT_MACROS_SVH
`define ECHO_COMMAND_LINK_SEQUENCER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ECLS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ecls assertion failed");

// next-cycle implication
`define ECLS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ecls assertion failed");

`else

`define ECLS_ASSERT_IMP(lbl, ante, cons)
`define ECLS_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

FILE: design/ecls_pkg.sv
// ----------------------------------------------------------------------------
// ecls_pkg
// Types and constants shared by the echo command link sequencer.
// ----------------------------------------------------------------------------
package ecls_pkg;

  localparam int unsigned MAX_WORDS = 32;

  localparam logic [7:0] CH_YES = 8'h59;
  localparam logic [7:0] CH_NO  = 8'h4E;

  localparam logic [15:0] BYTE_TMO_RST  = 16'd10000;
  localparam logic [15:0] REPLY_TMO_RST = 16'd30000;

  // transfer modes
  localparam logic [1:0] MODE_ECHO  = 2'd0;
  localparam logic [1:0] MODE_REPLY = 2'd1;
  localparam logic [1:0] MODE_RECV  = 2'd2;
  localparam logic [1:0] MODE_SEND  = 2'd3;

  // result buffer
  localparam int unsigned RB_DEPTH = 8;
  localparam int unsigned RB_BURST = 4;
  localparam int unsigned RB_AW    = $clog2(RB_DEPTH);

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_BYTE  = 2'd1,
    REQ_TICK  = 2'd2,
    REQ_WORD  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    KIND_TX_BYTE = 2'd0,
    KIND_RX_WORD = 2'd1,
    KIND_FINISH  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_TIMEOUT    = 3'd1,
    ST_MISMATCH   = 3'd2,
    ST_UNEXPECTED = 3'd3,
    ST_NO         = 3'd4,
    ST_BUSY       = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_ECHO  = 3'd1,
    PH_RX    = 3'd2,
    PH_TX    = 3'd3,
    PH_REPLY = 3'd4
  } phase_t;

  typedef struct packed {
    logic [31:0] tx_word;
    logic [7:0]  rx_byte;
    logic [5:0]  word_count;
    logic [1:0]  xfer_mode;
    logic [7:0]  command_byte;
    req_t        req_type;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  tx_byte;
    logic [31:0] rx_word;
    logic [4:0]  word_index;
    status_t     status;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [2:0]                 cnt;
    result_t [RB_BURST-1:0]     item;
  } res_set_t;

  function automatic result_t mk_finish(status_t st);
    result_t r;
    r            = '0;
    r.kind       = KIND_FINISH;
    r.status     = st;
    r.last       = 1'b1;
    return r;
  endfunction

  function automatic result_t mk_tx_byte(logic [7:0] b, logic lst);
    result_t r;
    r         = '0;
    r.kind    = KIND_TX_BYTE;
    r.tx_byte = b;
    r.last    = lst;
    return r;
  endfunction

endpackage

FILE: design/ecls_rbuf.sv
// ----------------------------------------------------------------------------
// ecls_rbuf
// Result queue: up to four results per accepted word, drains one a ready cycle.
// ----------------------------------------------------------------------------
`include "echo_command_link_sequencer_unit_macros.svh"

module ecls_rbuf
  import ecls_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  res_set_t push_set,
  output logic     room,
  output logic     out_valid,
  input  logic     out_ready,
  output result_t  out_res
);

  result_t           mem [RB_DEPTH];
  logic [RB_AW-1:0]  wptr_r, wptr_nxt;
  logic [RB_AW-1:0]  rptr_r, rptr_nxt;
  logic [RB_AW:0]    cnt_r, cnt_nxt;
  logic [2:0]        push_n;
  logic              pop;

  assign push_n    = push ? push_set.cnt : 3'd0;
  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && out_ready;
  assign room      = (cnt_r <= (RB_AW+1)'(RB_DEPTH - RB_BURST));
  assign out_res   = mem[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r + RB_AW'(push_n);
    rptr_nxt = rptr_r + RB_AW'(pop);
    cnt_nxt  = cnt_r + (RB_AW+1)'(push_n) - (RB_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < RB_BURST; k++) begin
      if (k < int'(push_n)) begin
        mem[wptr_r + RB_AW'(k)] <= push_set.item[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  `ECLS_ASSERT_IMP(a_rb_bound, 1'b1, cnt_r <= (RB_AW+1)'(RB_DEPTH))
  `ECLS_ASSERT_IMP(a_rb_push_room, push_n != 3'd0, room)
  `ECLS_ASSERT_NXT(a_rb_pop_only, pop && (push_n == 3'd0), cnt_r == $past(cnt_r) - 1'b1)

endmodule

FILE: design/ecls_core.sv
// ----------------------------------------------------------------------------
// ecls_core
// Exchange sequencer: phase, counters and results for one accepted word.
// ----------------------------------------------------------------------------
`include "echo_command_link_sequencer_unit_macros.svh"

module ecls_core
  import ecls_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  in_item_t    item,
  input  logic [15:0] byte_tmo,
  input  logic [15:0] reply_tmo,
  output res_set_t    res
);

  phase_t       phase_r, phase_nxt;
  logic [7:0]   cmd_r, cmd_nxt;
  logic [1:0]   mode_r, mode_nxt;
  logic [5:0]   wleft_r, wleft_nxt;
  logic [4:0]   wpos_r, wpos_nxt;
  logic [1:0]   bpos_r, bpos_nxt;
  logic [23:0]  shift_r, shift_nxt;
  logic [15:0]  ticks_r, ticks_nxt;

  logic [15:0]  ticks_inc;
  logic [15:0]  limit;
  logic         timed;
  logic         tmo_hit;
  logic [5:0]   wleft_dec;
  logic [5:0]   cnt_sat;

  assign ticks_inc = ticks_r + 16'd1;
  assign limit     = (phase_r == PH_REPLY) ? reply_tmo : byte_tmo;
  assign timed     = (phase_r == PH_ECHO) || (phase_r == PH_RX) || (phase_r == PH_REPLY);
  assign tmo_hit   = timed && (ticks_inc >= limit);
  assign wleft_dec = (wleft_r != 6'd0) ? wleft_r - 6'd1 : 6'd0;
  assign cnt_sat   = ({1'b0, item.word_count} > 7'(MAX_WORDS)) ? 6'(MAX_WORDS)
                                                                : item.word_count;

  // next state
  always_comb begin
    phase_nxt = phase_r;
    cmd_nxt   = cmd_r;
    mode_nxt  = mode_r;
    wleft_nxt = wleft_r;
    wpos_nxt  = wpos_r;
    bpos_nxt  = bpos_r;
    shift_nxt = shift_r;
    ticks_nxt = ticks_r;
    unique case (item.req_type)
      REQ_START: begin
        if (phase_r == PH_IDLE) begin
          cmd_nxt   = item.command_byte;
          mode_nxt  = item.xfer_mode;
          wleft_nxt = cnt_sat;
          wpos_nxt  = '0;
          bpos_nxt  = '0;
          shift_nxt = '0;
          ticks_nxt = '0;
          phase_nxt = PH_ECHO;
        end
      end
      REQ_TICK: begin
        if (timed) begin
          ticks_nxt = ticks_inc;
          if (tmo_hit) begin
            phase_nxt = PH_IDLE;
            ticks_nxt = '0;
          end
        end
      end
      REQ_WORD: begin
        if (phase_r == PH_TX) begin
          wleft_nxt = wleft_dec;
          wpos_nxt  = wpos_r + 5'd1;
          if (wleft_dec == 6'd0) begin
            phase_nxt = PH_REPLY;
            ticks_nxt = '0;
          end
        end
      end
      REQ_BYTE: begin
        unique case (phase_r)
          PH_ECHO: begin
            ticks_nxt = '0;
            if ((item.rx_byte != cmd_r) || (mode_r == MODE_ECHO)) begin
              phase_nxt = PH_IDLE;
            end else if ((mode_r == MODE_REPLY) || (wleft_r == 6'd0)) begin
              phase_nxt = PH_REPLY;
            end else begin
              phase_nxt = (mode_r == MODE_RECV) ? PH_RX : PH_TX;
            end
          end
          PH_RX: begin
            ticks_nxt = '0;
            if (bpos_r == 2'd3) begin
              wpos_nxt  = wpos_r + 5'd1;
              bpos_nxt  = '0;
              shift_nxt = '0;
              wleft_nxt = wleft_dec;
              if (wleft_dec == 6'd0) begin
                phase_nxt = PH_REPLY;
              end
            end else begin
              shift_nxt = {shift_r[15:0], item.rx_byte};
              bpos_nxt  = bpos_r + 2'd1;
            end
          end
          PH_REPLY: begin
            phase_nxt = PH_IDLE;
            ticks_nxt = '0;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // results
  always_comb begin
    res = '0;
    unique case (item.req_type)
      REQ_START: begin
        res.cnt = 3'd1;
        if (phase_r != PH_IDLE) begin
          res.item[0] = mk_finish(ST_BUSY);
        end else begin
          res.item[0] = mk_tx_byte(item.command_byte, 1'b1);
        end
      end
      REQ_TICK: begin
        if (tmo_hit) begin
          res.cnt     = 3'd1;
          res.item[0] = mk_finish(ST_TIMEOUT);
        end
      end
      REQ_WORD: begin
        if (phase_r == PH_TX) begin
          res.cnt     = 3'd4;
          res.item[0] = mk_tx_byte(item.tx_word[31:24], 1'b0);
          res.item[1] = mk_tx_byte(item.tx_word[23:16], 1'b0);
          res.item[2] = mk_tx_byte(item.tx_word[15:8], 1'b0);
          res.item[3] = mk_tx_byte(item.tx_word[7:0], 1'b1);
        end
      end
      REQ_BYTE: begin
        unique case (phase_r)
          PH_ECHO: begin
            if (item.rx_byte != cmd_r) begin
              res.cnt     = 3'd1;
              res.item[0] = mk_finish(ST_MISMATCH);
            end else if (mode_r == MODE_ECHO) begin
              res.cnt     = 3'd1;
              res.item[0] = mk_finish(ST_OK);
            end
          end
          PH_RX: begin
            if (bpos_r == 2'd3) begin
              res.cnt                = 3'd1;
              res.item[0].kind       = KIND_RX_WORD;
              res.item[0].rx_word    = {shift_r, item.rx_byte};
              res.item[0].word_index = wpos_r;
              res.item[0].status     = ST_OK;
              res.item[0].last       = 1'b1;
            end
          end
          PH_REPLY: begin
            res.cnt = 3'd1;
            if (item.rx_byte == CH_YES) begin
              res.item[0] = mk_finish(ST_OK);
            end else if (item.rx_byte == CH_NO) begin
              res.item[0] = mk_finish(ST_NO);
            end else begin
              res.item[0] = mk_finish(ST_UNEXPECTED);
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cmd_r   <= '0;
      mode_r  <= '0;
      wleft_r <= '0;
      wpos_r  <= '0;
      bpos_r  <= '0;
      shift_r <= '0;
      ticks_r <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      cmd_r   <= cmd_nxt;
      mode_r  <= mode_nxt;
      wleft_r <= wleft_nxt;
      wpos_r  <= wpos_nxt;
      bpos_r  <= bpos_nxt;
      shift_r <= shift_nxt;
      ticks_r <= ticks_nxt;
    end
  end

  `ECLS_ASSERT_NXT(a_idle_stays,
                   accept && (phase_r == PH_IDLE) && (item.req_type != REQ_START),
                   phase_r == PH_IDLE)
  `ECLS_ASSERT_NXT(a_start_echo,
                   accept && (phase_r == PH_IDLE) && (item.req_type == REQ_START),
                   (phase_r == PH_ECHO) && (ticks_r == 16'd0))
  `ECLS_ASSERT_IMP(a_rx_pos_zero,
                   (phase_r == PH_ECHO) || (phase_r == PH_TX) || (phase_r == PH_REPLY),
                   (bpos_r == 2'd0) && (shift_r == 24'd0))

endmodule

FILE: design/echo_command_link_sequencer_unit.sv
// ----------------------------------------------------------------------------
// echo_command_link_sequencer_unit
// Host side of a byte-link echo/command exchange with per-wait timeouts.
// ----------------------------------------------------------------------------
// Input stream: one word per event (start, received link byte, 1 ms tick,
// word to transmit), kind in in_tuser. Output stream: bytes to put on the
// link, received words and one finish word with a status per exchange;
// kind in out_tuser, out_tlast marks the final result of an input word.
// APB port: byte timeout at 0x0, reply timeout at 0x4 (16 bits each).
// Results of an input word are queued when the word is accepted and leave
// the queue in order. An input word is taken every cycle while the result
// queue holds four or fewer entries; a word to transmit yields four results,
// which drain one per cycle while out_tready is high and set the sustained rate.
// Reset: phase returns to idle, counters clear, the result queue empties
// and the timeouts return to 10000 and 30000 ticks.
// Receiver stall: results stay queued (eight entries); once more than four
// are pending in_tready drops until the output drains.
// ----------------------------------------------------------------------------
module echo_command_link_sequencer_unit
  import ecls_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // command_byte, xfer_mode, word_count, rx_byte, tx_word
  input  logic [1:0]  in_tuser,   // req_type
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // tx_byte, rx_word, word_index, status
  output logic [1:0]  out_tuser,  // out_kind
  output logic        out_tlast,
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [15:0] byte_tmo_r;
  logic [15:0] reply_tmo_r;
  logic        cfg_wr;
  logic        accept;
  in_item_t    item;
  res_set_t    res;
  result_t     ores;
  logic        room;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = cfg_paddr[2] ? {16'd0, reply_tmo_r} : {16'd0, byte_tmo_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_tmo_r  <= BYTE_TMO_RST;
      reply_tmo_r <= REPLY_TMO_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[2]) begin
        reply_tmo_r <= cfg_pwdata[15:0];
      end else begin
        byte_tmo_r <= cfg_pwdata[15:0];
      end
    end
  end

  assign in_tready = room;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    item.req_type     = req_t'(in_tuser);
    item.command_byte = in_tdata[7:0];
    item.xfer_mode    = in_tdata[9:8];
    item.word_count   = in_tdata[15:10];
    item.rx_byte      = in_tdata[23:16];
    item.tx_word      = in_tdata[55:24];
  end

  ecls_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .item      (item),
    .byte_tmo  (byte_tmo_r),
    .reply_tmo (reply_tmo_r),
    .res       (res)
  );

  ecls_rbuf u_rbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_set  (res),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (ores)
  );

  assign out_tuser = ores.kind;
  assign out_tlast = ores.last;
  assign out_tdata = {ores.status, ores.word_index, ores.rx_word, ores.tx_byte};

endmodule

FILE: sim/tb_echo_command_link_sequencer_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_echo_command_link_sequencer_unit
// Self-checking bench for the echo command link sequencer. A directed table
// walks start, echo, reply, receive and send exchanges, the busy, mismatch,
// NO, unexpected-reply and ignored-word cases. Random exchanges then run
// under several timeout settings, including zero, one and the maximum. Every
// result word is checked against a typed table row or an in-bench exchange model.
// ----------------------------------------------------------------------------
module tb_echo_command_link_sequencer_unit;
  import ecls_pkg::*;

  localparam logic [2:0] ADDR_BYTE_TMO  = 3'h0;
  localparam logic [2:0] ADDR_REPLY_TMO = 3'h4;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 8;

  typedef struct packed {
    req_t        req;
    logic [7:0]  cmd;
    logic [1:0]  mode;
    logic [5:0]  cnt;
    logic [7:0]  rxb;
    logic [31:0] txw;
    logic        typed;
    kind_t       kind;
    logic [7:0]  txb;
    status_t     st;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;   // command_byte, xfer_mode, word_count, rx_byte, tx_word
  logic [1:0]  in_tuser;   // req_type
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // tx_byte, rx_word, word_index, status
  logic [1:0]  out_tuser;  // out_kind
  logic        out_tlast;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  echo_command_link_sequencer_unit u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // exchange model state
  phase_t      ph       = PH_IDLE;
  logic [7:0]  sv_cmd   = '0;
  logic [1:0]  sv_mode  = '0;
  logic [5:0]  left     = '0;
  logic [4:0]  wpos     = '0;
  logic [1:0]  bpos     = '0;
  logic [23:0] shreg    = '0;
  logic [15:0] ticks    = '0;
  logic [15:0] byte_lim  = BYTE_TMO_RST;
  logic [15:0] reply_lim = REPLY_TMO_RST;

  result_t     step_results[$];
  result_t     pending_results[$];

  in_item_t    cur_item;
  logic        cur_typed;
  result_t     cur_expect;
  result_t     got;
  result_t     want;

  bit          idle_on = 1'b1;
  int          hold_req = 0;
  int          hold_done = 0;
  int          hold_left = 0;
  int          cycles = 0;
  int          n_errors = 0;
  int          n_accepted = 0;
  int          n_results = 0;
  int          n_sent = 0;
  int          n_exchanges = 0;

  dir_row_t    dir_rows [28];

  function automatic result_t link_result(kind_t k, logic [7:0] b, logic [31:0] w,
                                          logic [4:0] idx, status_t st, logic lst);
    result_t r;
    r.kind       = k;
    r.tx_byte    = b;
    r.rx_word    = w;
    r.word_index = idx;
    r.status     = st;
    r.last       = lst;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] g, input logic [31:0] w);
    n_errors++;
    $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, g, w);
  endtask

  task automatic close_exchange(input status_t st);
    ph    = PH_IDLE;
    ticks = '0;
    step_results.push_back(link_result(KIND_FINISH, 8'h00, 32'h0, 5'd0, st, 1'b1));
  endtask

  task automatic predict_link_results(input in_item_t it);
    logic [15:0] lim;
    bit          timed;
    lim   = '0;
    timed = 1'b0;
    case (it.req_type)
      REQ_START: begin
        if (ph != PH_IDLE) begin
          step_results.push_back(link_result(KIND_FINISH, 8'h00, 32'h0, 5'd0, ST_BUSY, 1'b1));
        end else begin
          sv_cmd  = it.command_byte;
          sv_mode = it.xfer_mode;
          left    = (it.word_count > MAX_WORDS) ? 6'(MAX_WORDS) : it.word_count;
          wpos    = '0;
          bpos    = '0;
          shreg   = '0;
          ticks   = '0;
          ph      = PH_ECHO;
          step_results.push_back(link_result(KIND_TX_BYTE, it.command_byte, 32'h0, 5'd0,
                                             ST_OK, 1'b1));
        end
      end
      REQ_TICK: begin
        if (ph == PH_ECHO || ph == PH_RX) begin
          lim   = byte_lim;
          timed = 1'b1;
        end else if (ph == PH_REPLY) begin
          lim   = reply_lim;
          timed = 1'b1;
        end
        if (timed) begin
          ticks = ticks + 16'd1;
          if (ticks >= lim) close_exchange(ST_TIMEOUT);
        end
      end
      REQ_WORD: begin
        if (ph == PH_TX) begin
          for (int k = 0; k < 4; k++)
            step_results.push_back(link_result(KIND_TX_BYTE, it.tx_word[24-8*k +: 8], 32'h0,
                                               5'd0, ST_OK, k == 3));
          if (left != 0) left--;
          wpos++;
          if (left == 0) begin
            ph    = PH_REPLY;
            ticks = '0;
          end
        end
      end
      default: begin
        case (ph)
          PH_ECHO: begin
            if (it.rx_byte != sv_cmd) close_exchange(ST_MISMATCH);
            else if (sv_mode == MODE_ECHO) close_exchange(ST_OK);
            else begin
              ticks = '0;
              if (sv_mode == MODE_REPLY || left == 0) ph = PH_REPLY;
              else ph = (sv_mode == MODE_RECV) ? PH_RX : PH_TX;
            end
          end
          PH_RX: begin
            ticks = '0;
            if (bpos == 2'd3) begin
              step_results.push_back(link_result(KIND_RX_WORD, 8'h00, {shreg, it.rx_byte}, wpos,
                                                 ST_OK, 1'b1));
              wpos++;
              bpos  = '0;
              shreg = '0;
              if (left != 0) left--;
              if (left == 0) ph = PH_REPLY;
            end else begin
              shreg = {shreg[15:0], it.rx_byte};
              bpos++;
            end
          end
          PH_REPLY: begin
            if (it.rx_byte == CH_YES) close_exchange(ST_OK);
            else if (it.rx_byte == CH_NO) close_exchange(ST_NO);
            else close_exchange(ST_UNEXPECTED);
          end
          default: begin
          end
        endcase
      end
    endcase
  endtask

  // input acceptance feeds the model, result words are checked in order
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      step_results.delete();
      predict_link_results(cur_item);
      if (cur_typed) pending_results.push_back(cur_expect);
      else foreach (step_results[i]) pending_results.push_back(step_results[i]);
      n_accepted++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      got.kind       = kind_t'(out_tuser);
      got.tx_byte    = out_tdata[7:0];
      got.rx_word    = out_tdata[39:8];
      got.word_index = out_tdata[44:40];
      got.status     = status_t'(out_tdata[47:45]);
      got.last       = out_tlast;
      n_results++;
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected result word", 32'(got.kind), 32'hffffffff);
      end else begin
        want = pending_results.pop_front();
        if (got.kind != want.kind) flag_mismatch("kind", 32'(got.kind), 32'(want.kind));
        if (got.tx_byte != want.tx_byte) flag_mismatch("tx_byte", 32'(got.tx_byte),
                                                       32'(want.tx_byte));
        if (got.rx_word != want.rx_word) flag_mismatch("rx_word", got.rx_word, want.rx_word);
        if (got.word_index != want.word_index)
          flag_mismatch("word_index", 32'(got.word_index), 32'(want.word_index));
        if (got.status != want.status) flag_mismatch("status", 32'(got.status),
                                                     32'(want.status));
        if (got.last != want.last) flag_mismatch("last", 32'(got.last), 32'(want.last));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_req != hold_done) begin
      hold_done  <= hold_req;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= !(idle_on && $urandom_range(99) < 34);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic in_item_t rnd_item(req_t r);
    in_item_t it;
    it.tx_word      = $urandom;
    it.rx_byte      = 8'($urandom);
    it.word_count   = 6'($urandom);
    it.xfer_mode    = 2'($urandom);
    it.command_byte = 8'($urandom);
    it.req_type     = r;
    return it;
  endfunction

  task automatic send_item(input in_item_t it, input logic typed, input result_t ex);
    while (idle_on && $urandom_range(99) < 34) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    cur_item   <= it;
    cur_typed  <= typed;
    cur_expect <= ex;
    in_tdata   <= {it.tx_word, it.rx_byte, it.word_count, it.xfer_mode, it.command_byte};
    in_tuser   <= it.req_type;
    in_tvalid  <= 1'b1;
    do @(posedge clk); while (!in_tready);
    n_sent++;
  endtask

  task automatic send_ticks(input int n);
    for (int i = 0; i < n; i++) send_item(rnd_item(REQ_TICK), 1'b0, '0);
  endtask

  task automatic tick_noise();
    int r;
    r = $urandom_range(99);
    if (r >= 95) send_ticks($urandom_range(2, 10));
    else if (r >= 80) send_ticks(1);
  endtask

  // occasional start mid-exchange or a fully random word
  task automatic stray_noise();
    int r;
    r = $urandom_range(99);
    if (r < 3) send_item(rnd_item(REQ_START), 1'b0, '0);
    else if (r < 5) send_item(rnd_item(req_t'($urandom_range(3))), 1'b0, '0);
  endtask

  task automatic run_exchange(input bit big);
    in_item_t   it;
    logic [1:0] mode;
    logic [7:0] cmd;
    int         cnt;
    int         nw;
    int         r;
    mode = 2'($urandom_range(3));
    cmd  = 8'($urandom);
    r    = $urandom_range(99);
    if (big) cnt = $urandom_range(32, 63);
    else if (r < 70) cnt = $urandom_range(0, 3);
    else cnt = $urandom_range(4, 8);
    n_exchanges++;
    it              = rnd_item(REQ_START);
    it.command_byte = cmd;
    it.xfer_mode    = mode;
    it.word_count   = 6'(cnt);
    send_item(it, 1'b0, '0);
    tick_noise();
    it         = rnd_item(REQ_BYTE);
    it.rx_byte = ($urandom_range(99) < 90) ? cmd : 8'($urandom);
    send_item(it, 1'b0, '0);
    nw = (cnt > MAX_WORDS) ? MAX_WORDS : cnt;
    if (mode == MODE_RECV) begin
      for (int i = 0; i < nw * 4; i++) begin
        stray_noise();
        tick_noise();
        send_item(rnd_item(REQ_BYTE), 1'b0, '0);
      end
    end else if (mode == MODE_SEND) begin
      for (int i = 0; i < nw; i++) begin
        stray_noise();
        if ($urandom_range(99) < 5) send_item(rnd_item(REQ_BYTE), 1'b0, '0);
        send_item(rnd_item(REQ_WORD), 1'b0, '0);
      end
    end
    if (mode != MODE_ECHO) begin
      tick_noise();
      it = rnd_item(REQ_BYTE);
      r  = $urandom_range(99);
      if (r < 60) it.rx_byte = CH_YES;
      else if (r < 80) it.rx_byte = CH_NO;
      else if (r >= 90) send_ticks($urandom_range(1, 12));
      send_item(it, 1'b0, '0);
    end
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic apb_access(input logic [2:0] addr, input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_timeouts(input logic [15:0] bt, input logic [15:0] rt);
    logic [31:0] rd;
    apb_access(ADDR_BYTE_TMO, 1'b1, {16'h0, bt}, rd);
    apb_access(ADDR_REPLY_TMO, 1'b1, {16'h0, rt}, rd);
    byte_lim  = bt;
    reply_lim = rt;
    apb_access(ADDR_BYTE_TMO, 1'b0, 32'h0, rd);
    if (rd != {16'h0, bt}) flag_mismatch("byte timeout readback", rd, {16'h0, bt});
    apb_access(ADDR_REPLY_TMO, 1'b0, 32'h0, rd);
    if (rd != {16'h0, rt}) flag_mismatch("reply timeout readback", rd, {16'h0, rt});
  endtask

  initial begin
    in_item_t    it;
    logic [15:0] byte_set [7];
    logic [15:0] reply_set [7];
    int          budget;
    int          start_sent;

    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= REQ_START;
    cur_item    <= '0;
    cur_typed   <= 1'b0;
    cur_expect  <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;

    dir_rows = '{
      '{REQ_START, 8'hFF, MODE_ECHO,  6'd63, 8'h00, 32'h0, 1'b1, KIND_TX_BYTE, 8'hFF, ST_OK},
      '{REQ_BYTE,  8'h00, MODE_ECHO,  6'd0,  8'hFF, 32'h0, 1'b1, KIND_FINISH,  8'h00, ST_OK},
      '{REQ_START, 8'h00, MODE_REPLY, 6'd0,  8'h00, 32'h0, 1'b1, KIND_TX_BYTE, 8'h00, ST_OK},
      '{REQ_START, 8'h5A, MODE_RECV,  6'd63, 8'h00, 32'h0, 1'b1, KIND_FINISH,  8'h00, ST_BUSY},
      '{REQ_BYTE,  8'h00, MODE_ECHO,  6'd0,  8'h00, 32'h0, 1'b0, KIND_TX_BYTE, 8'h00, ST_OK},
      '{REQ_TICK,  8'h00, MODE_ECHO,  6'd0,  8'h00, 32'h0, 1'b0, KIND_TX_BYTE, 8'h00, ST_OK},
      '{REQ_BYTE,  8'h00, MODE_ECHO,  6'd0,  CH_NO, 32'h0, 1'b1, KIND_FINISH,  8'h00, ST_NO},
      '{REQ_START, 8'h41, MODE_ECHO,  6'd0,  8'h00, 32'h0, 1'b1, KIND_TX_BYTE, 8'h41, ST_OK},
      '{REQ_BYTE,  8'h00, MODE_ECHO,  6'd0,  8'h42, 32'h0, 1'b1, KIND_FINISH,  8'h00,
        ST_MISMATCH},
      '{REQ_START, 8'h52, MODE_RECV,  6'd1,  8'h00, 32'h0, 1'b1, KIND_TX_BYTE, 8'h52, ST_OK},
      '{REQ_BYTE,  8'h00, MODE_ECHO,  6'd0,  8'h52, 32'h0, 1'b0, KIND_TX_BYTE, 8'h00, ST_OK},
      '{REQ_BYTE,  8'h00, MODE_ECHO,  6'd0,  8'h12, 32'h0, 1'b0, KIND_TX_BYTE, 8'h00, ST_OK},
      '{REQ_BYTE,  8'h00, MODE_ECHO,  6'd0,  8'h34, 32'h0, 1'b0, KIND_TX_BYTE, 8'h00, ST_OK},
      '{REQ_BYTE,  8'h00, MODE_ECHO,  6'd0,  8'h56, 32'h0, 1'b0, KIND_TX_BYTE, 8'h00, ST_OK},
      '{REQ_BYTE,  8'h00, MODE_ECHO,  6'd0,  8'h78, 32'h0, 1'b0, KIND_TX_BYTE, 8'h00, ST_OK},
      '{REQ_BYTE,  8'h00, MODE_ECHO,  6'd0, CH_YES, 32'h0, 1'b1, KIND_FINISH,  8'h00, ST_OK},
      '{REQ_START, 8'h53, MODE_SEND,  6'd1,  8'h00, 32'h0, 1'b1, KIND_TX_BYTE, 8'h53, ST_OK},
      '{REQ_BYTE,  8'h00, MODE_ECHO,  6'd0,  8'h53, 32'h0, 1'b0, KIND_TX_BYTE, 8'h00, ST_OK},
      '{REQ_TICK,  8'h00, MODE_ECHO,  6'd0,  8'h00, 32'h0, 1'b0, KIND_TX_BYTE, 8'h00, ST_OK},
      '{REQ_BYTE,  8'h00, MODE_ECHO,  6'd0,  8'h99, 32'h0, 1'b0, KIND_TX_BYTE, 8'h00, ST_OK},
      '{REQ_WORD,  8'h00, MODE_ECHO,  6'd0,  8'h00, 32'hFFFFFFFF, 1'b0, KIND_TX_BYTE, 8'h00,
        ST_OK},
      '{REQ_BYTE,  8'h00, MODE_ECHO,  6'd0,  8'h58, 32'h0, 1'b1, KIND_FINISH,  8'h00,
        ST_UNEXPECTED},
      '{REQ_WORD,  8'h00, MODE_ECHO,  6'd0,  8'h00, 32'h0, 1'b0, KIND_TX_BYTE, 8'h00, ST_OK},
      '{REQ_TICK,  8'h00, MODE_ECHO,  6'd0,  8'h00, 32'h0, 1'b0, KIND_TX_BYTE, 8'h00, ST_OK},
      '{REQ_BYTE,  8'h00, MODE_ECHO,  6'd0,  8'h7E, 32'h0, 1'b0, KIND_TX_BYTE, 8'h00, ST_OK},
      '{REQ_START, 8'h54, MODE_RECV,  6'd0,  8'h00, 32'h0, 1'b1, KIND_TX_BYTE, 8'h54, ST_OK},
      '{REQ_BYTE,  8'h00, MODE_ECHO,  6'd0,  8'h54, 32'h0, 1'b0, KIND_TX_BYTE, 8'h00, ST_OK},
      '{REQ_BYTE,  8'h00, MODE_ECHO,  6'd0, CH_YES, 32'h0, 1'b1, KIND_FINISH,  8'h00, ST_OK}
    };
    byte_set  = '{16'd5, 16'd1, 16'd65535, 16'd0, 16'd3, 16'd12, 16'd2};
    reply_set = '{16'd7, 16'd1, 16'd65535, 16'd0, 16'd8, 16'd4, 16'd65535};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table at reset timeouts
    foreach (dir_rows[i]) begin
      it.req_type     = dir_rows[i].req;
      it.command_byte = dir_rows[i].cmd;
      it.xfer_mode    = dir_rows[i].mode;
      it.word_count   = dir_rows[i].cnt;
      it.rx_byte      = dir_rows[i].rxb;
      it.tx_word      = dir_rows[i].txw;
      send_item(it, dir_rows[i].typed,
                link_result(dir_rows[i].kind, dir_rows[i].txb, 32'h0, 5'd0, dir_rows[i].st,
                            1'b1));
    end
    in_tvalid <= 1'b0;

    // random exchanges, one timeout setting per phase
    foreach (byte_set[p]) begin
      wait_drained();
      set_timeouts(byte_set[p], reply_set[p]);
      idle_on = (p != 5);
      if (p == 2) hold_req++;
      budget     = (p == 3) ? 20 : 55;
      start_sent = n_sent;
      if (p == 2) run_exchange(1'b1);
      while (n_sent - start_sent < budget) begin
        if ($urandom_range(99) < 8) send_item(rnd_item(req_t'($urandom_range(3))), 1'b0, '0);
        else run_exchange($urandom_range(99) < 3);
      end
      in_tvalid <= 1'b0;
    end
    idle_on = 1'b1;
    wait_drained();

    $display("Run covered %0d input words and %0d result words over %0d random exchanges,",
             n_accepted, n_results, n_exchanges);
    $display("with %0d timeout settings, a long output hold and a stretch with no idling.",
             $size(byte_set) + 1);
    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: echo_command_link_sequencer_unit.f
+incdir+design
design/ecls_pkg.sv
design/ecls_rbuf.sv
design/ecls_core.sv
design/echo_command_link_sequencer_unit.sv
sim/tb_echo_command_link_sequencer_unit.sv
